### sv/fsms_pkg.sv
// shared types, constants and character helpers for the subsequence match scorer
// no dependencies; used by fsms_ctrl, fsms_dp and the top level
package fsms_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 256;
  localparam int RAW_LIMIT   = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
  localparam int CNT_W       = $clog2(MAX_TEXT + 1);
  localparam int SL_W        = $clog2(MAX_PATTERN + 1);
  localparam int PI_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SCORE_W     = 32;
  localparam int OUT_W       = 30;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_MIN   = -score_t'(536870912);
  localparam score_t SCORE_NEVER = -score_t'(1073741824);

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_LOWER = 2'd1;
  localparam logic [1:0] CLS_UPPER = 2'd2;

  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_TAIL = 2'd1;
  localparam logic [1:0] ROLE_HEAD = 2'd2;

  localparam logic [1:0] CFG_PAT_LO  = 2'd0;
  localparam logic [1:0] CFG_PAT_HI  = 2'd1;
  localparam logic [1:0] CFG_PAT_LEN = 2'd2;
  localparam logic [1:0] CFG_CASE    = 2'd3;

  localparam logic [1:0] CASE_INSENS = 2'd0;
  localparam logic [1:0] CASE_SMART  = 2'd1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic scan_clr;
    logic load_en;
    logic init_en;
    logic step_en;
    logic final_en;
    logic out_load;
  } fsms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic raw_empty;
    logic scan_last;
    logic cnt_zero;
    logic item_empty;
    logic item_last;
  } fsms_sts_t;

  function automatic logic [1:0] class_of(input logic [7:0] c);
    logic [1:0] r;
    r = CLS_OTHER;
    if (c >= 8'h61 && c <= 8'h7a) r = CLS_LOWER;
    else if (c >= 8'h41 && c <= 8'h5a) r = CLS_UPPER;
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [1:0] role_of(input logic [1:0] pre, input logic [1:0] cur,
                                         input logic [1:0] suc);
    logic [1:0] r;
    if (cur == CLS_OTHER) r = ROLE_NONE;
    else if (pre == CLS_OTHER ||
             (cur == CLS_UPPER && (pre == CLS_LOWER || suc == CLS_LOWER))) r = ROLE_HEAD;
    else r = ROLE_TAIL;
    return r;
  endfunction

endpackage

### sv/fuzzy_subsequence_match_score.sv
// subsequence match scorer: one text byte per request, a score on the last byte
// a text's first request adds a pattern scan over the raw pattern bytes (spaces included)
// and a column setup; each byte is accepted, then steps the column, and the last byte also
// runs a final step and loads the result register; in_stall holds off a new byte until idle
// reset clears configuration to its defaults and empties the result register
// depends on fsms_pkg, fsms_ctrl and fsms_dp
module fuzzy_subsequence_match_score import fsms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [63:0]             cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_text_char,
  input  logic                    in_last_char,
  input  logic                    in_empty_text,
  input  logic                    in_strict,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_score
);

  fsms_cmd_t cmd;
  fsms_sts_t sts;

  // sequencer
  fsms_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_empty_text (in_empty_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // score datapath
  fsms_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_text_char  (in_text_char),
    .in_last_char  (in_last_char),
    .in_empty_text (in_empty_text),
    .in_strict     (in_strict),
    .cmd           (cmd),
    .sts           (sts),
    .out_score     (out_score)
  );

endmodule

### sv/fsms_ctrl.sv
// sequencing state machine for the subsequence match scorer
// depends on fsms_pkg; drives commands into fsms_dp and owns the result valid
module fsms_ctrl import fsms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_empty_text,
  output logic      out_valid,
  input  logic      out_stall,
  input  fsms_sts_t sts,
  output fsms_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_INIT   = 6'b000100,
    ST_STEP   = 6'b001000,
    ST_FINAL  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.cap = 1'b1;
          if (in_empty_text || sts.cnt_zero) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = sts.raw_empty ? ST_INIT : ST_LOAD;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_en = 1'b1;
        if (sts.scan_last) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init_en = 1'b1;
        state_nxt   = sts.item_empty ? ST_RESULT : ST_STEP;
      end
      ST_STEP: begin
        cmd.step_en = 1'b1;
        state_nxt   = sts.item_last ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        cmd.final_en = 1'b1;
        state_nxt    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/fsms_dp.sv
// datapath: configuration, pattern strip scan, per-row score cells, best score
// depends on fsms_pkg; commanded by fsms_ctrl
module fsms_dp import fsms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [63:0]             cfg_wdata,
  input  logic [7:0]              in_text_char,
  input  logic                    in_last_char,
  input  logic                    in_empty_text,
  input  logic                    in_strict,
  input  fsms_cmd_t               cmd,
  output fsms_sts_t               sts,
  output logic signed [OUT_W-1:0] out_score
);

  // configuration registers
  logic [63:0] pat_lo_r, pat_hi_r;
  logic [4:0]  pat_len_r;
  logic [1:0]  case_mode_r;

  // captured request
  logic [7:0] item_char_r;
  logic       item_last_r, item_empty_r, item_strict_r;

  // pattern scan
  logic [3:0]      scan_k_r;
  logic [SL_W-1:0] strip_len_r;
  logic            has_upper_r, exact_r;
  logic [7:0]      strip_r [MAX_PATTERN];
  logic [1:0]      prole_r [MAX_PATTERN];

  // text state
  score_t          miss_r [MAX_PATTERN+1];
  score_t          hit_r  [MAX_PATTERN+1];
  logic [7:0]      held_r;
  logic [1:0]      prior_r;
  logic [CNT_W-1:0] cnt_r;
  score_t          best_r;
  logic            ovf_r, strict_r, sfail_r;
  logic signed [OUT_W-1:0] score_r;

  logic [127:0] pat_all;
  logic [4:0]   raw_len;
  logic [7:0]   sc_b;
  logic [1:0]   sc_cur, sc_pre, sc_suc, sc_role;

  assign pat_all = {pat_hi_r, pat_lo_r};
  assign raw_len = (pat_len_r > 5'(RAW_LIMIT)) ? 5'(RAW_LIMIT) : pat_len_r;

  // classify the scanned pattern byte against its neighbors
  always_comb begin
    sc_b   = pat_all[8*scan_k_r +: 8];
    sc_cur = class_of(sc_b);
    sc_pre = (scan_k_r == 4'd0) ? CLS_OTHER : class_of(pat_all[8*(scan_k_r - 4'd1) +: 8]);
    sc_suc = ((5'(scan_k_r) + 5'd1) < raw_len) ?
             class_of(pat_all[8*(scan_k_r + 4'd1) +: 8]) : sc_cur;
    sc_role = role_of(sc_pre, sc_cur, sc_suc);
  end

  assign sts.raw_empty  = (raw_len == 5'd0);
  assign sts.scan_last  = ((5'(scan_k_r) + 5'd1) == raw_len);
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.item_empty = item_empty_r;
  assign sts.item_last  = item_last_r;

  // settle of the held text byte
  logic             settle_en;
  logic [1:0]       t_cur, t_suc, t_role;
  logic [CNT_W-1:0] col_j;
  score_t           nm [MAX_PATTERN+1];
  score_t           nh [MAX_PATTERN+1];
  score_t           hit_end, floor_v, best_nxt;
  logic             sfail_set;

  assign settle_en = !ovf_r && ((cmd.step_en && cnt_r != '0) || cmd.final_en);
  assign t_cur     = class_of(held_r);
  assign t_suc     = cmd.final_en ? t_cur : class_of(item_char_r);
  assign t_role    = role_of(prior_r, t_cur, t_suc);
  assign col_j     = cnt_r - CNT_W'(1);

  function automatic score_t miss_pen(input logic [1:0] role, input logic after_hit);
    score_t s;
    s = -score_t'(3);
    if (after_hit) s = s - score_t'(10);
    if (role == ROLE_HEAD) s = s - score_t'(10);
    return s;
  endfunction

  function automatic score_t hit_gain(input logic eq, input logic bonus, input logic p_head,
                                      input logic [1:0] role, input logic row0,
                                      input logic after_hit);
    score_t s;
    s = '0;
    if (eq) s = bonus ? score_t'(2) : score_t'(1);
    if (p_head) begin
      if (role == ROLE_HEAD) s = s + score_t'(30);
      else if (role == ROLE_TAIL) s = s - score_t'(10);
    end
    if (role == ROLE_TAIL && !row0 && !after_hit) s = s - score_t'(30);
    if (row0 && role == ROLE_TAIL) s = s - score_t'(40);
    return s;
  endfunction

  // one score cell per pattern row
  always_comb begin
    logic   eq, ok, bonus, row0, p_head;
    score_t a, b;
    nm[0] = miss_r[0] + miss_pen(t_role, 1'b0);
    nh[0] = SCORE_NEVER;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq     = (strip_r[i] == held_r);
      row0   = (i == 0);
      p_head = (prole_r[i] == ROLE_HEAD);
      bonus  = has_upper_r || ({{(32-CNT_W){1'b0}}, col_j} == 32'(i));
      if (exact_r) ok = eq;
      else ok = (fold(strip_r[i]) == fold(held_r)) && (!row0 || t_role != ROLE_TAIL || eq);
      if ({{(32-CNT_W){1'b0}}, col_j} < 32'(i)) begin
        nm[i+1] = miss_r[i+1];
        nh[i+1] = hit_r[i+1];
      end else begin
        a = miss_r[i+1] + miss_pen(t_role, 1'b0);
        b = hit_r[i+1] + miss_pen(t_role, 1'b1);
        nm[i+1] = (a > b) ? a : b;
        a = miss_r[i] + hit_gain(eq, bonus, p_head, t_role, row0, 1'b0);
        b = hit_r[i] + hit_gain(eq, bonus, p_head, t_role, row0, 1'b1);
        nh[i+1] = ok ? ((a > b) ? a : b) : SCORE_NEVER;
      end
    end
  end

  // running best end score and strict first-role check
  always_comb begin
    hit_end  = nh[strip_len_r];
    floor_v  = ((best_r - score_t'(2)) > SCORE_MIN) ? (best_r - score_t'(2)) : SCORE_MIN;
    best_nxt = (hit_end > floor_v) ? hit_end : floor_v;
    sfail_set = (col_j == '0) && strict_r && (strip_len_r != '0) &&
                ((prole_r[0] != ROLE_NONE) != (t_role != ROLE_NONE));
  end

  // result selection
  logic signed [OUT_W-1:0] score_nxt;
  always_comb begin
    if (item_empty_r) begin
      score_nxt = (strip_len_r == '0) ? '0 : OUT_W'(SCORE_MIN);
    end else if (strip_len_r == '0) begin
      score_nxt = OUT_W'(SCORE_MIN);
    end else if (ovf_r) begin
      score_nxt = OUT_W'(SCORE_MIN + score_t'(1));
    end else if (sfail_r) begin
      score_nxt = OUT_W'(SCORE_MIN);
    end else begin
      score_nxt = OUT_W'(best_r);
    end
  end

  assign out_score = score_r;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      pat_len_r   <= '0;
      case_mode_r <= CASE_SMART;
      scan_k_r    <= '0;
      strip_len_r <= '0;
      has_upper_r <= 1'b0;
      exact_r     <= 1'b0;
      held_r      <= '0;
      prior_r     <= CLS_OTHER;
      cnt_r       <= '0;
      best_r      <= SCORE_MIN;
      ovf_r       <= 1'b0;
      strict_r    <= 1'b0;
      sfail_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAT_LO:  pat_lo_r    <= cfg_wdata;
          CFG_PAT_HI:  pat_hi_r    <= cfg_wdata;
          CFG_PAT_LEN: pat_len_r   <= cfg_wdata[4:0];
          CFG_CASE:    case_mode_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      // pattern strip scan, one raw byte a cycle
      if (cmd.scan_clr) begin
        scan_k_r    <= '0;
        strip_len_r <= '0;
        has_upper_r <= 1'b0;
      end else if (cmd.load_en) begin
        scan_k_r <= scan_k_r + 4'd1;
        if (sc_cur == CLS_UPPER) has_upper_r <= 1'b1;
        if (sc_b != CHAR_SPACE && strip_len_r < SL_W'(MAX_PATTERN))
          strip_len_r <= strip_len_r + SL_W'(1);
      end
      if (cmd.init_en) begin
        exact_r  <= (case_mode_r == CASE_INSENS) ? 1'b0 :
                    ((case_mode_r == CASE_SMART) ? has_upper_r : 1'b1);
        held_r   <= '0;
        prior_r  <= CLS_OTHER;
        cnt_r    <= '0;
        best_r   <= SCORE_MIN;
        ovf_r    <= 1'b0;
        strict_r <= item_strict_r;
        sfail_r  <= 1'b0;
      end else begin
        if (settle_en) begin
          best_r  <= best_nxt;
          prior_r <= t_cur;
          if (sfail_set) sfail_r <= 1'b1;
        end
        if (cmd.step_en) begin
          if (cnt_r >= CNT_W'(MAX_TEXT)) begin
            ovf_r <= 1'b1;
          end else begin
            held_r <= item_char_r;
            cnt_r  <= cnt_r + CNT_W'(1);
          end
        end
        if (cmd.out_load) cnt_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_char_r   <= in_text_char;
      item_last_r   <= in_last_char;
      item_empty_r  <= in_empty_text;
      item_strict_r <= in_strict;
    end
    if (cmd.load_en && sc_b != CHAR_SPACE && strip_len_r < SL_W'(MAX_PATTERN)) begin
      strip_r[strip_len_r[PI_W-1:0]] <= sc_b;
      prole_r[strip_len_r[PI_W-1:0]] <= sc_role;
    end
    if (cmd.init_en) begin
      for (int r = 0; r <= MAX_PATTERN; r++) begin
        miss_r[r] <= (r == 0) ? score_t'(0) : SCORE_MIN;
        hit_r[r]  <= (r == 0) ? score_t'(0) : SCORE_MIN;
      end
    end else if (settle_en) begin
      for (int r = 0; r <= MAX_PATTERN; r++) begin
        miss_r[r] <= nm[r];
        hit_r[r]  <= nh[r];
      end
    end
    if (cmd.out_load) score_r <= score_nxt;
  end

endmodule
